FILE: sv/melody_tone_sequencer_macros.svh
// ----------------------------------------------------------------------------
// melody_tone_sequencer assertion macros
// shared assertion forms, clocked on i_clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef MELODY_TONE_SEQUENCER_MACROS_SVH
`define MELODY_TONE_SEQUENCER_MACROS_SVH

// same-cycle implication
`define MTS_ASSERT_IMP(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error(msg);

// next-cycle implication
`define MTS_ASSERT_NXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

FILE: sv/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// types, command codes and constants of the melody tone sequencer
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int MAX_ENTRIES     = 16;
    localparam int ADDR_W          = $clog2(MAX_ENTRIES);
    localparam int LEN_W           = 5;
    localparam int GLIDE_PERIOD_MS = 10;
    localparam int MS_PER_S        = 1000;
    localparam int FREQ_W          = 16;
    localparam int PROD_W          = 2 * FREQ_W;
    localparam int HP_W            = 24;
    localparam int STEP_W          = FREQ_W + 1;

    // duration / GLIDE_PERIOD_MS by reciprocal multiplication
    localparam int GLIDE_RECIP_SHIFT = FREQ_W + $clog2(GLIDE_PERIOD_MS);
    localparam int GLIDE_RECIP_W     = FREQ_W + 1;
    localparam longint GLIDE_RECIP   =
        ((64'd1 << GLIDE_RECIP_SHIFT) + GLIDE_PERIOD_MS - 1) / GLIDE_PERIOD_MS;

    // shared serial divider, two quotient bits per cycle
    localparam int STEPS_W   = $clog2(65535 / GLIDE_PERIOD_MS + 1);
    localparam int MS_W      = $clog2(MS_PER_S + 1);
    localparam int DIV_DEN_W = (STEPS_W > MS_W) ? STEPS_W : MS_W;
    localparam int DIV_NUM_W = PROD_W + 2;
    localparam int DIV_STEPS = DIV_NUM_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_WRITE  = 3'd1;
    localparam logic [2:0] CMD_START  = 3'd2;
    localparam logic [2:0] CMD_STOP   = 3'd3;
    localparam logic [2:0] CMD_TOGGLE = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  entry_index;
        logic        entry_glide;
        logic [15:0] entry_frequency;
        logic [15:0] entry_duration;
        logic [4:0]  melody_length;
        logic [15:0] repeat_count;
    } t_in_item;

    typedef struct packed {
        logic        pin_level;
        logic [15:0] tone_frequency;
        logic        frequency_set;
        logic        playing;
    } t_out_item;

    typedef struct packed {
        logic              glide;
        logic [FREQ_W-1:0] freq;
        logic [15:0]       dur;
    } t_tone_entry;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

FILE: sv/melody_tone_sequencer.sv
// ----------------------------------------------------------------------------
// melody_tone_sequencer
// buzzer melody player driven by commands and tone timer ticks
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_stall carries command items (tick, table
// write, start, stop, manual toggle). Every item yields exactly one result
// item on o_out_valid / i_out_stall: pin level, the tone timer frequency last
// requested, a flag when this item requested it, and the playing status.
// One item is worked at a time. Write, stop, toggle, idle ticks and ticks in
// the middle of a tone go from acceptance straight to the result state. An
// item that loads a fixed entry, or a glide step, makes one pass through the
// shared two-bit-per-cycle divider (half-period count); loading a glide entry
// makes two (glide step, then half-period count). The tone table is a 16-entry
// synchronous memory, read in the cycle before its use.
// The next item is accepted once the result register is free or being taken;
// while the receiver stalls, the result holds and no new item enters.
// Reset clears all playback state: silent, pin low, frequency zero. Table
// contents are undefined until written.
// ----------------------------------------------------------------------------
module melody_tone_sequencer
    import mts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_LOAD,
        S_STEP_DIV,
        S_GLIDE_MUL,
        S_HP_START,
        S_HP_DIV,
        S_TICK,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [LEN_W-1:0]    r_play_len;
    logic [ADDR_W-1:0]   r_ptr;
    logic [15:0]         r_repeats;
    logic [HP_W-1:0]     r_hp;
    logic [FREQ_W-1:0]   r_cf;
    logic [STEP_W-1:0]   r_step;
    logic                r_pin;
    logic [FREQ_W-1:0]   r_timer_freq;
    logic                r_freq_set;
    logic [PROD_W-1:0]   r_prod;
    logic                r_step_neg;
    logic                r_out_valid;
    t_out_item           r_out_item;

    t_tone_entry         r_mem [MAX_ENTRIES];
    t_tone_entry         r_mem_q;

    logic                w_in_acc;
    logic                w_mem_we;
    logic [ADDR_W-1:0]   w_rd_addr;
    logic [LEN_W-1:0]    w_len;
    logic [LEN_W:0]      w_ptr_inc;
    logic                w_use_entry;
    logic [FREQ_W-1:0]   w_mul_a;
    logic [FREQ_W-1:0]   w_mul_b;
    logic [PROD_W-1:0]   w_prod;
    logic [FREQ_W+GLIDE_RECIP_W-1:0] w_recip_prod;
    logic [DIV_DEN_W-1:0] w_steps_raw;
    logic [DIV_DEN_W-1:0] w_steps;
    logic [STEP_W-1:0]   w_diff;
    logic [STEP_W-1:0]   w_diff_abs;
    logic [STEP_W-1:0]   w_step_mag;
    logic [STEP_W:0]     w_nf_sum;
    logic [STEP_W:0]     w_target;
    logic                w_clip;
    logic [FREQ_W-1:0]   w_nf;
    logic                w_moves_on;
    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);

    assign w_mem_we  = w_in_acc && (i_in_item.cmd == CMD_WRITE)
                       && ({1'b0, i_in_item.entry_index} < 5'(MAX_ENTRIES));
    assign w_rd_addr = (r_state == S_IDLE && i_in_item.cmd == CMD_START) ? '0 : r_ptr;

    // tone table
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[i_in_item.entry_index[ADDR_W-1:0]] <= '{glide: i_in_item.entry_glide,
                                                          freq:  i_in_item.entry_frequency,
                                                          dur:   i_in_item.entry_duration};
        end
        r_mem_q <= r_mem[w_rd_addr];
    end

    always_comb begin
        if (i_in_item.melody_length == '0) begin
            w_len = LEN_W'(1);
        end else if (i_in_item.melody_length > LEN_W'(MAX_ENTRIES)) begin
            w_len = LEN_W'(MAX_ENTRIES);
        end else begin
            w_len = i_in_item.melody_length;
        end
    end

    assign w_ptr_inc = {1'b0, {(LEN_W-ADDR_W){1'b0}}, r_ptr} + 1'b1;

    // one multiplier: freq * duration for a fixed entry, else glide freq * period
    assign w_use_entry = (r_state == S_LOAD) && !r_mem_q.glide;
    assign w_mul_a     = w_use_entry ? r_mem_q.freq : r_cf;
    assign w_mul_b     = w_use_entry ? r_mem_q.dur : FREQ_W'(GLIDE_PERIOD_MS);
    assign w_prod      = w_mul_a * w_mul_b;

    // glide step count, at least one
    assign w_recip_prod = r_mem_q.dur * GLIDE_RECIP_W'(GLIDE_RECIP);
    assign w_steps_raw  = DIV_DEN_W'(w_recip_prod >> GLIDE_RECIP_SHIFT);
    assign w_steps      = (w_steps_raw == '0) ? DIV_DEN_W'(1) : w_steps_raw;

    assign w_diff     = {1'b0, r_mem_q.freq} - {1'b0, r_cf};
    assign w_diff_abs = w_diff[STEP_W-1] ? (~w_diff + 1'b1) : w_diff;
    assign w_step_mag = w_div_rsp.quotient[STEP_W-1:0];

    // next glide frequency, clipped at the target
    assign w_nf_sum = {2'b00, r_cf} + {r_step[STEP_W-1], r_step};
    assign w_target = {2'b00, r_mem_q.freq};
    assign w_clip   = (r_step == '0)
                      || (!r_step[STEP_W-1] && ($signed(w_nf_sum) > $signed(w_target)))
                      || (r_step[STEP_W-1] && ($signed(w_nf_sum) < $signed(w_target)));
    assign w_nf     = w_clip ? r_mem_q.freq : w_nf_sum[FREQ_W-1:0];

    assign w_moves_on = !r_mem_q.glide || (r_cf == r_mem_q.freq);

    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.dividend = {1'b0, r_prod, 1'b0};
        w_div_req.divisor  = DIV_DEN_W'(MS_PER_S);
        if (r_state == S_LOAD && r_mem_q.glide) begin
            w_div_req.start    = 1'b1;
            w_div_req.dividend = DIV_NUM_W'(w_diff_abs);
            w_div_req.divisor  = w_steps;
        end else if (r_state == S_HP_START) begin
            w_div_req.start = 1'b1;
        end
    end

    mts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_play_len   <= '0;
            r_ptr        <= '0;
            r_repeats    <= '0;
            r_hp         <= '0;
            r_cf         <= '0;
            r_step       <= '0;
            r_pin        <= 1'b0;
            r_timer_freq <= '0;
            r_freq_set   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_freq_set <= 1'b0;
                        r_state    <= S_DONE;
                        unique case (i_in_item.cmd)
                            CMD_TICK: begin
                                if (r_repeats != '0) begin
                                    r_pin <= ~r_pin;
                                    if (r_hp != '0) begin
                                        r_hp <= r_hp - 1'b1;
                                    end else begin
                                        r_state <= S_TICK;
                                    end
                                end
                            end
                            CMD_START: begin
                                r_play_len <= w_len;
                                r_repeats  <= i_in_item.repeat_count;
                                r_ptr      <= '0;
                                r_state    <= S_START;
                            end
                            CMD_STOP: begin
                                r_repeats <= '0;
                                r_pin     <= 1'b0;
                            end
                            CMD_TOGGLE: begin
                                r_pin <= ~r_pin;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_START: begin
                    r_cf    <= r_mem_q.freq;
                    r_state <= S_LOAD;
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_prod     <= w_prod;
                    r_freq_set <= 1'b1;
                    if (r_mem_q.glide) begin
                        r_timer_freq <= r_cf;
                        r_step_neg   <= w_diff[STEP_W-1];
                        r_state      <= S_STEP_DIV;
                    end else begin
                        r_timer_freq <= r_mem_q.freq;
                        r_state      <= S_HP_START;
                    end
                end
                S_STEP_DIV: begin
                    if (w_div_rsp.done) begin
                        r_step  <= r_step_neg ? (~w_step_mag + 1'b1) : w_step_mag;
                        r_state <= S_HP_START;
                    end
                end
                S_GLIDE_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_HP_START;
                end
                S_HP_START: begin
                    r_state <= S_HP_DIV;
                end
                S_HP_DIV: begin
                    if (w_div_rsp.done) begin
                        r_hp    <= w_div_rsp.quotient[HP_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_TICK: begin
                    if (w_moves_on) begin
                        if (w_ptr_inc >= {1'b0, r_play_len}) begin
                            if (r_repeats == 16'd1) begin
                                // last repeat done: go silent
                                r_repeats <= '0;
                                r_pin     <= 1'b0;
                                r_state   <= S_DONE;
                            end else begin
                                r_repeats <= r_repeats - 1'b1;
                                r_ptr     <= '0;
                                r_state   <= S_READ;
                            end
                        end else begin
                            r_ptr   <= w_ptr_inc[ADDR_W-1:0];
                            r_state <= S_READ;
                        end
                    end else begin
                        r_cf         <= w_nf;
                        r_timer_freq <= w_nf;
                        r_freq_set   <= 1'b1;
                        r_state      <= S_GLIDE_MUL;
                    end
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result fields, captured when the item completes
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            r_out_item.pin_level      <= r_pin;
            r_out_item.tone_frequency <= r_timer_freq;
            r_out_item.frequency_set  <= r_freq_set;
            r_out_item.playing        <= (r_repeats != '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: sv/mts_div.sv
// ----------------------------------------------------------------------------
// mts_div
// unsigned restoring divider, two quotient bits per cycle, done pulse at end
// ----------------------------------------------------------------------------
module mts_div
    import mts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   w_rem1;
    logic [DIV_DEN_W:0]   w_rem1s;
    logic [DIV_DEN_W:0]   w_rem2;
    logic [DIV_DEN_W:0]   w_rem2s;
    logic                 w_ge1;
    logic                 w_ge2;

    always_comb begin
        w_rem1  = {r_rem, r_num[DIV_NUM_W-1]};
        w_ge1   = (w_rem1 >= {1'b0, r_den});
        w_rem1s = w_ge1 ? (w_rem1 - {1'b0, r_den}) : w_rem1;
        w_rem2  = {w_rem1s[DIV_DEN_W-1:0], r_num[DIV_NUM_W-2]};
        w_ge2   = (w_rem2 >= {1'b0, r_den});
        w_rem2s = w_ge2 ? (w_rem2 - {1'b0, r_den}) : w_rem2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
                r_num  <= i_req.dividend;
                r_rem  <= '0;
                r_den  <= i_req.divisor;
            end else if (r_busy) begin
                // quotient bits shift in at the bottom as dividend bits leave the top
                r_num <= {r_num[DIV_NUM_W-3:0], w_ge1, w_ge2};
                r_rem <= w_rem2s[DIV_DEN_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_num;

endmodule

FILE: sv/mts_checker.sv
// ----------------------------------------------------------------------------
// mts_checker
// port-level checks of the melody tone sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "melody_tone_sequencer_macros.svh"

module mts_checker
    import mts_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && !o_in_stall;

    `MTS_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall,
                    o_out_valid && $stable(o_out_item), "stalled result changed")

    `MTS_ASSERT_NXT(a_one_item, w_in_acc, o_in_stall,
                    "item accepted while another is in work")

    `MTS_ASSERT_IMP(a_no_overrun, o_out_valid && i_out_stall, o_in_stall,
                    "item accepted while result is blocked")

    `MTS_ASSERT_IMP(a_stop_silent,
                    $rose(o_out_valid) && $past(w_in_acc && (i_in_item.cmd == CMD_STOP), 2),
                    !o_out_item.playing && !o_out_item.pin_level,
                    "stop did not silence the pin")

endmodule

bind melody_tone_sequencer mts_checker u_mts_checker (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// melody tone sequencer bench: a directed command script, then random table
// writes, melodies, ticks, stops and toggles; every result item is checked in
// order against set script values, else a behavioral player model in the bench
// ----------------------------------------------------------------------------
module tb_top;
    import mts_pkg::*;

    localparam int ITEM_GOAL    = 450;
    localparam int IDLE_PCT     = 33;
    localparam int HOLD_AFTER   = 120;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_AT     = 330;
    localparam int STEADY_FROM  = 180;
    localparam int STEADY_TO    = 260;
    localparam int TAIL_CYCLES  = 60;
    localparam int STALL_LIMIT  = 2000;

    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    typedef struct {
        t_in_item  item;
        int        count;
        bit        typed;
        t_out_item want;
    } t_script_row;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    bit          steady        = 1'b0;
    int          mismatches    = 0;
    int          statuses_seen = 0;
    int          quiet_cycles  = 0;
    t_out_item   status_due[$];
    t_script_row script[$];

    // player model state
    t_tone_entry             slot_table [MAX_ENTRIES];
    logic [LEN_W-1:0]        tune_len      = '0;
    logic [LEN_W-1:0]        slot_ptr      = '0;
    logic [15:0]             repeats_due   = '0;
    logic [HP_W-1:0]         half_periods  = '0;
    logic [FREQ_W-1:0]       glide_freq    = '0;
    logic signed [STEP_W-1:0] glide_inc    = '0;
    logic                    pin_state     = 1'b0;
    logic [FREQ_W-1:0]       timer_freq    = '0;
    logic                    timer_freq_new = 1'b0;

    melody_tone_sequencer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void issue_tone(input logic [FREQ_W-1:0] freq, input logic [15:0] ms);
        longint span;
        span = (longint'(freq) * 2 * longint'(ms)) / MS_PER_S;
        half_periods   = span[HP_W-1:0];
        timer_freq     = freq;
        timer_freq_new = 1'b1;
    endfunction

    function automatic void load_slot();
        t_tone_entry e;
        int steps;
        int diff;
        e = slot_table[slot_ptr[ADDR_W-1:0]];
        if (!e.glide) begin
            issue_tone(e.freq, e.dur);
        end else begin
            steps = int'(e.dur) / GLIDE_PERIOD_MS;
            if (steps < 1)
                steps = 1;
            diff = int'(e.freq) - int'(glide_freq);
            glide_inc = diff / steps;
            issue_tone(glide_freq, GLIDE_PERIOD_MS);
        end
    endfunction

    function automatic void go_silent();
        repeats_due = '0;
        pin_state   = 1'b0;
    endfunction

    // false once the last repeat has ended
    function automatic bit advance_slot();
        slot_ptr++;
        if (slot_ptr >= tune_len) begin
            if (repeats_due != 0) begin
                repeats_due--;
                if (repeats_due == 0) begin
                    go_silent();
                    return 1'b0;
                end
            end
            slot_ptr = '0;
        end
        return 1'b1;
    endfunction

    function automatic void play_tick();
        t_tone_entry e;
        int nf;
        if (repeats_due == 0)
            return;
        pin_state = ~pin_state;
        if (half_periods != 0) begin
            half_periods--;
            return;
        end
        e = slot_table[slot_ptr[ADDR_W-1:0]];
        if (!e.glide || glide_freq == e.freq) begin
            if (advance_slot())
                load_slot();
        end else begin
            nf = int'(glide_freq) + int'(glide_inc);
            // clip at the target, and a zero step jumps straight there
            if (glide_inc == 0 || (glide_inc > 0 && nf > int'(e.freq)) ||
                    (glide_inc < 0 && nf < int'(e.freq)))
                nf = int'(e.freq);
            glide_freq = nf[FREQ_W-1:0];
            issue_tone(glide_freq, GLIDE_PERIOD_MS);
        end
    endfunction

    function automatic t_out_item player_step(input t_in_item it);
        t_out_item res;
        int len;
        timer_freq_new = 1'b0;
        case (it.cmd)
            CMD_TICK: play_tick();
            CMD_WRITE: begin
                slot_table[it.entry_index].glide = it.entry_glide;
                slot_table[it.entry_index].freq  = it.entry_frequency;
                slot_table[it.entry_index].dur   = it.entry_duration;
            end
            CMD_START: begin
                len = int'(it.melody_length);
                if (len < 1)
                    len = 1;
                if (len > MAX_ENTRIES)
                    len = MAX_ENTRIES;
                tune_len    = LEN_W'(len);
                repeats_due = it.repeat_count;
                slot_ptr    = '0;
                glide_freq  = slot_table[0].freq;
                load_slot();
            end
            CMD_STOP:   go_silent();
            CMD_TOGGLE: pin_state = ~pin_state;
            default: ;
        endcase
        res.pin_level      = pin_state;
        res.tone_frequency = timer_freq;
        res.frequency_set  = timer_freq_new;
        res.playing        = (repeats_due != 0);
        return res;
    endfunction

    function automatic void add_row(input logic [2:0] cmd, input logic [3:0] slot,
            input logic glide, input logic [15:0] freq, input logic [15:0] dur,
            input logic [4:0] len, input logic [15:0] reps, input int count);
        t_script_row r;
        r.item.cmd             = cmd;
        r.item.entry_index     = slot;
        r.item.entry_glide     = glide;
        r.item.entry_frequency = freq;
        r.item.entry_duration  = dur;
        r.item.melody_length   = len;
        r.item.repeat_count    = reps;
        r.count = count;
        r.typed = 1'b0;
        r.want  = '0;
        script.push_back(r);
    endfunction

    function automatic void expect_row(input logic pin, input logic [15:0] freq,
            input logic set, input logic play);
        int last;
        last = script.size() - 1;
        script[last].typed               = 1'b1;
        script[last].want.pin_level      = pin;
        script[last].want.tone_frequency = freq;
        script[last].want.frequency_set  = set;
        script[last].want.playing        = play;
    endfunction

    function automatic t_in_item noise_item();
        t_in_item it;
        it.cmd             = 3'($urandom);
        it.entry_index     = 4'($urandom);
        it.entry_glide     = 1'($urandom);
        it.entry_frequency = 16'($urandom);
        it.entry_duration  = 16'($urandom);
        it.melody_length   = 5'($urandom);
        it.repeat_count    = 16'($urandom);
        return it;
    endfunction

    // mostly short low tones so melodies run to their end, now and then anything
    function automatic t_in_item slot_write(input logic [3:0] slot);
        t_in_item it;
        it = noise_item();
        it.cmd         = CMD_WRITE;
        it.entry_index = slot;
        if ($urandom_range(15) != 0) begin
            it.entry_frequency = 16'($urandom_range(100));
            it.entry_duration  = 16'($urandom_range(50));
        end
        return it;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int pick;
        logic [2:0] spare;
        it    = noise_item();
        pick  = $urandom_range(99);
        spare = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
        if (repeats_due != 0)
            it.cmd = (pick < 78) ? CMD_TICK : (pick < 86) ? CMD_WRITE :
                     (pick < 90) ? CMD_START : (pick < 93) ? CMD_STOP :
                     (pick < 97) ? CMD_TOGGLE : spare;
        else
            it.cmd = (pick < 55) ? CMD_START : (pick < 75) ? CMD_WRITE :
                     (pick < 85) ? CMD_TOGGLE : (pick < 91) ? CMD_STOP :
                     (pick < 95) ? CMD_TICK : spare;
        case (it.cmd)
            CMD_WRITE: it = slot_write(it.entry_index);
            CMD_START: begin
                if ($urandom_range(9) != 0)
                    it.melody_length = 5'($urandom_range(5));
                pick = $urandom_range(9);
                if (pick == 0)
                    it.repeat_count = '0;
                else if (pick > 1)
                    it.repeat_count = 16'($urandom_range(3, 1));
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item model;
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        model = player_step(it);
        status_due.push_back(typed ? want : model);
    endtask

    task automatic check_status(input t_out_item want, input t_out_item got);
        if (got.pin_level !== want.pin_level) begin
            $display("%0t: pin_level expected %0d got %0d", $time, want.pin_level,
                got.pin_level);
            mismatches++;
        end
        if (got.tone_frequency !== want.tone_frequency) begin
            $display("%0t: tone_frequency expected %0d got %0d", $time,
                want.tone_frequency, got.tone_frequency);
            mismatches++;
        end
        if (got.frequency_set !== want.frequency_set) begin
            $display("%0t: frequency_set expected %0d got %0d", $time,
                want.frequency_set, got.frequency_set);
            mismatches++;
        end
        if (got.playing !== want.playing) begin
            $display("%0t: playing expected %0d got %0d", $time, want.playing,
                got.playing);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            statuses_seen++;
            if (status_due.size() == 0) begin
                $display("%0t: result item with none expected, got %h", $time, out_item);
                mismatches++;
            end else begin
                check_status(status_due.pop_front(), out_item);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off to back the block up
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(negedge clk);
            if (!held && statuses_seen >= HOLD_AFTER) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin
        t_in_item it;
        int useful;
        int n;

        // idle player, toggle, spare code, stop
        add_row(CMD_TICK,      4'd0, 1'b0, 16'd0,     16'd0,     5'd0,  16'd0,     1);
        expect_row(1'b0, 16'd0, 1'b0, 1'b0);
        add_row(CMD_TOGGLE,    4'd0, 1'b0, 16'd0,     16'd0,     5'd0,  16'd0,     1);
        expect_row(1'b1, 16'd0, 1'b0, 1'b0);
        add_row(CMD_SPARE_HI,  4'd0, 1'b0, 16'd0,     16'd0,     5'd0,  16'd0,     1);
        expect_row(1'b1, 16'd0, 1'b0, 1'b0);
        add_row(CMD_STOP,      4'd0, 1'b0, 16'd0,     16'd0,     5'd0,  16'd0,     1);
        expect_row(1'b0, 16'd0, 1'b0, 1'b0);
        // fixed, overshooting glide, short glide, zero-step glide
        add_row(CMD_WRITE,     4'd0, 1'b0, 16'd40,    16'd10,    5'd0,  16'd0,     1);
        expect_row(1'b0, 16'd0, 1'b0, 1'b0);
        add_row(CMD_WRITE,     4'd1, 1'b1, 16'd45,    16'd25,    5'd0,  16'd0,     1);
        expect_row(1'b0, 16'd0, 1'b0, 1'b0);
        add_row(CMD_WRITE,     4'd2, 1'b1, 16'd20,    16'd5,     5'd0,  16'd0,     1);
        expect_row(1'b0, 16'd0, 1'b0, 1'b0);
        add_row(CMD_WRITE,     4'd3, 1'b1, 16'd30,    16'd200,   5'd0,  16'd0,     1);
        expect_row(1'b0, 16'd0, 1'b0, 1'b0);
        // zero repeats with length zero: tone requested, stays silent
        add_row(CMD_START,     4'd0, 1'b0, 16'd0,     16'd0,     5'd0,  16'd0,     1);
        expect_row(1'b0, 16'd40, 1'b1, 1'b0);
        add_row(CMD_TICK,      4'd0, 1'b0, 16'd0,     16'd0,     5'd0,  16'd0,     1);
        expect_row(1'b0, 16'd40, 1'b0, 1'b0);
        // one full pass to the end of the melody
        add_row(CMD_START,     4'd0, 1'b0, 16'd0,     16'd0,     5'd4,  16'd1,     1);
        add_row(CMD_TICK,      4'd0, 1'b0, 16'd0,     16'd0,     5'd0,  16'd0,     9);
        add_row(CMD_START,     4'd0, 1'b0, 16'd0,     16'd0,     5'd2,  16'hffff,  1);
        add_row(CMD_WRITE,     4'd1, 1'b0, 16'd10,    16'd20,    5'd0,  16'd0,     1);
        add_row(CMD_TICK,      4'd0, 1'b0, 16'd0,     16'd0,     5'd0,  16'd0,     3);
        add_row(CMD_TOGGLE,    4'd0, 1'b0, 16'd0,     16'd0,     5'd0,  16'd0,     1);
        add_row(CMD_STOP,      4'd0, 1'b0, 16'd0,     16'd0,     5'd0,  16'd0,     1);
        add_row(CMD_WRITE,     4'd0, 1'b0, 16'hffff,  16'hffff,  5'd0,  16'd0,     1);
        add_row(CMD_START,     4'd0, 1'b0, 16'd0,     16'd0,     5'd1,  16'd1,     1);
        add_row(CMD_TICK,      4'd0, 1'b0, 16'd0,     16'd0,     5'd0,  16'd0,     2);
        add_row(CMD_STOP,      4'd0, 1'b0, 16'd0,     16'd0,     5'd0,  16'd0,     1);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[r])
            repeat (script[r].count)
                send_item(script[r].item, script[r].typed, script[r].want);

        // fill the whole table so any melody length reads written slots
        for (int s = 0; s < MAX_ENTRIES; s++)
            send_item(slot_write(4'(s)), 1'b0, '0);

        useful = 0;
        n = 0;
        while (useful < ITEM_GOAL) begin
            steady = (useful >= STEADY_FROM && useful < STEADY_TO);
            if (n == DRAIN_AT) begin
                @(negedge clk);
                in_valid <= 1'b0;
                while (status_due.size() != 0)
                    @(posedge clk);
            end
            it = random_item();
            if (it.cmd <= CMD_TOGGLE && !(it.cmd == CMD_TICK && repeats_due == 0))
                useful++;
            send_item(it, 1'b0, '0);
            n++;
        end
        steady = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && status_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
